>>> rtl/bfa_pkg.sv
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int MAX_FRAMES_DEF = 8192;
  localparam int FRAME_W        = 20;
  localparam int SIZE_W         = 14;
  localparam int COUNT_W        = 14;
  localparam int ACTION_W       = 2;
  localparam int STATUS_W       = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 20;
  // bitmap rows are one byte of frames
  localparam int ROW_BITS       = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_MARK    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NONE_FREE   = 2'd1,
    STAT_OUT_OF_POOL = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE = 2'd0,
    CFG_POOL_SIZE = 2'd1,
    CFG_INFO      = 2'd2
  } cfg_idx_t;

  // classified request handed from front to back
  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_MARK    = 3'd2,
    OP_DONE_OK = 3'd3,
    OP_REJECT  = 3'd4
  } op_t;

endpackage

>>> rtl/bitmap_frame_allocator_unit.sv
`timescale 1ns / 1ps
// Flow: a reject or no-op is answered from the idle state; release reads and rewrites
//   one bitmap byte; allocate scans bytes from row 0 until a free frame or the pool end;
//   mark rewrites each byte of the range. The back end takes one request at a time.
// Reset: after rst_n the maps are cleared by a pass over all MAX_FRAMES/8 rows (1024 by
//   default), during which in_full is high; config resets to base 0, size 0, info 1.
module bitmap_frame_allocator_unit import bfa_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [FRAME_W-1:0]    in_frame_number,
  input  logic [COUNT_W-1:0]    in_range_count,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [FRAME_W-1:0]    out_frame_out,
  output logic [STATUS_W-1:0]   out_status
);

  localparam int ROWS  = (MAX_FRAMES + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OFF_W = ROW_W + 3;
  localparam int CNT_W = OFF_W + 1;

  logic               cmd_valid, cmd_pop, clearing, pool_info;
  op_t                cmd_op;
  logic [OFF_W-1:0]   cmd_off;
  logic [CNT_W-1:0]   cmd_end, pool_esz;
  logic [FRAME_W-1:0] pool_base;

  bfa_front #(.MAX_FRAMES(MAX_FRAMES), .OFF_W(OFF_W), .CNT_W(CNT_W)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_push, .in_full, .in_action, .in_frame_number, .in_range_count,
    .clearing, .cmd_valid, .cmd_pop, .cmd_op, .cmd_off, .cmd_end,
    .pool_base, .pool_esz, .pool_info
  );

  bfa_back #(.MAX_FRAMES(MAX_FRAMES), .ROWS(ROWS), .ROW_W(ROW_W), .OFF_W(OFF_W),
             .CNT_W(CNT_W)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_pop, .cmd_op, .cmd_off, .cmd_end,
    .pool_base, .pool_esz, .pool_info, .clearing,
    .out_empty, .out_pop, .out_frame_out, .out_status
  );

endmodule

>>> rtl/bfa_front.sv
`timescale 1ns / 1ps
module bfa_front import bfa_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int OFF_W      = 13,
  parameter int CNT_W      = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [FRAME_W-1:0]    in_frame_number,
  input  logic [COUNT_W-1:0]    in_range_count,
  // to back end
  input  logic                  clearing,
  output logic                  cmd_valid,
  input  logic                  cmd_pop,
  output op_t                   cmd_op,
  output logic [OFF_W-1:0]      cmd_off,
  output logic [CNT_W-1:0]      cmd_end,
  output logic [FRAME_W-1:0]    pool_base,
  output logic [CNT_W-1:0]      pool_esz,
  output logic                  pool_info
);

  logic [FRAME_W-1:0] base_r;
  logic [SIZE_W-1:0]  size_r;
  logic               info_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= '0;
      info_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POOL_BASE: base_r <= cfg_wdata[FRAME_W-1:0];
        CFG_POOL_SIZE: base_r <= base_r;
        CFG_INFO:      info_r <= cfg_wdata[0];
        default:       base_r <= base_r;
      endcase
      if (cfg_idx_t'(cfg_index) == CFG_POOL_SIZE) size_r <= cfg_wdata[SIZE_W-1:0];
    end
  end

  // clamp pool size to bitmap capacity
  logic [CNT_W-1:0] esz;
  always_comb begin
    if (32'(size_r) > 32'(MAX_FRAMES)) esz = CNT_W'(MAX_FRAMES);
    else                               esz = CNT_W'(size_r);
  end

  assign pool_base = base_r;
  assign pool_esz  = esz;
  assign pool_info = info_r;

  // range checks
  logic [FRAME_W+1:0] lim, fend;
  logic [FRAME_W-1:0] off_full;
  logic               lo_ok;
  op_t                cls_op;
  logic [OFF_W-1:0]   cls_off;
  logic [CNT_W-1:0]   cls_end;

  always_comb begin
    lim      = (FRAME_W+2)'(base_r) + (FRAME_W+2)'(esz);
    fend     = (FRAME_W+2)'(in_frame_number) + (FRAME_W+2)'(in_range_count);
    lo_ok    = in_frame_number >= base_r;
    off_full = in_frame_number - base_r;
    cls_off  = OFF_W'(off_full);
    cls_end  = CNT_W'(cls_off) + CNT_W'(in_range_count);
    case (action_t'(in_action))
      ACT_ALLOC:   cls_op = OP_ALLOC;
      ACT_RELEASE: cls_op = (lo_ok && ((FRAME_W+2)'(in_frame_number) < lim)) ?
                            OP_RELEASE : OP_REJECT;
      ACT_MARK: begin
        if (!lo_ok || (fend > lim))  cls_op = OP_REJECT;
        else if (in_range_count == '0) cls_op = OP_DONE_OK;
        else                          cls_op = OP_MARK;
      end
      default:     cls_op = OP_DONE_OK;
    endcase
  end

  // two-entry request queue
  op_t              q_op_r  [2];
  logic [OFF_W-1:0] q_off_r [2];
  logic [CNT_W-1:0] q_end_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push_ok;

  assign in_full   = (cnt_r == 2'd2) || clearing;
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd_op    = q_op_r[rp_r];
  assign cmd_off   = q_off_r[rp_r];
  assign cmd_end   = q_end_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_op_r[wp_r]  <= cls_op;
      q_off_r[wp_r] <= cls_off;
      q_end_r[wp_r] <= cls_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(cmd_pop);
    end
  end

endmodule

>>> rtl/bfa_back.sv
`timescale 1ns / 1ps
module bfa_back import bfa_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int ROWS       = 1024,
  parameter int ROW_W      = 10,
  parameter int OFF_W      = 13,
  parameter int CNT_W      = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  op_t                 cmd_op,
  input  logic [OFF_W-1:0]    cmd_off,
  input  logic [CNT_W-1:0]    cmd_end,
  input  logic [FRAME_W-1:0]  pool_base,
  input  logic [CNT_W-1:0]    pool_esz,
  input  logic                pool_info,
  output logic                clearing,
  // result channel
  output logic                out_empty,
  input  logic                out_pop,
  output logic [FRAME_W-1:0]  out_frame_out,
  output logic [STATUS_W-1:0] out_status
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EVAL  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  op_t                op_r;
  logic [OFF_W-1:0]   off_r;
  logic [CNT_W-1:0]   end_r;

  // bitmap memories, one byte of frames per row
  logic [ROW_BITS-1:0] used_mem [ROWS];
  logic [ROW_BITS-1:0] blk_mem  [ROWS];
  logic [ROW_BITS-1:0] rd_u_r, rd_b_r;
  logic                mem_we;
  logic [ROW_BITS-1:0] wu, wb;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[row_r] <= wu;
      blk_mem[row_r]  <= wb;
    end
    rd_u_r <= used_mem[row_r];
    rd_b_r <= blk_mem[row_r];
  end

  // per-row masks
  logic [CNT_W-1:0]    row_idx;
  logic [CNT_W-1:0]    idx_j;
  logic [ROW_BITS-1:0] amask, mmask, free;
  logic [2:0]          sel;
  logic                alloc_last, mark_last;
  logic [CNT_W-1:0]    end_m1;

  always_comb begin
    row_idx = CNT_W'({row_r, 3'b000});
    idx_j   = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      idx_j    = row_idx + CNT_W'(j);
      amask[j] = (idx_j < pool_esz) && !(pool_info && (idx_j == '0));
      mmask[j] = (idx_j >= CNT_W'(off_r)) && (idx_j < end_r);
    end
    free = ~(rd_u_r | rd_b_r) & amask;
    sel  = 3'd0;
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (free[j]) sel = 3'(j);
    end
    alloc_last = ((CNT_W+1)'(row_idx) + (CNT_W+1)'(ROW_BITS)) >= (CNT_W+1)'(pool_esz);
    end_m1     = end_r - CNT_W'(1);
    mark_last  = row_r == ROW_W'(end_m1 >> 3);
  end

  // result queue, two entries
  logic [FRAME_W-1:0]  oq_frame_r [2];
  status_t             oq_stat_r  [2];
  logic                owp_r, orp_r;
  logic [1:0]          ocnt_r;
  logic                res_push;
  logic [FRAME_W-1:0]  res_frame;
  status_t             res_stat;
  logic                res_pop;

  assign out_empty     = ocnt_r == 2'd0;
  assign res_pop       = out_pop && !out_empty;
  assign out_frame_out = oq_frame_r[orp_r];
  assign out_status    = oq_stat_r[orp_r];

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_frame_r[owp_r] <= res_frame;
      oq_stat_r[owp_r]  <= res_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (res_push) owp_r <= ~owp_r;
      if (res_pop)  orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + 2'(res_push) - 2'(res_pop);
    end
  end

  assign clearing = state_r == S_CLEAR;
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid && (ocnt_r != 2'd2);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    mem_we    = 1'b0;
    wu        = rd_u_r;
    wb        = rd_b_r;
    res_push  = 1'b0;
    res_frame = '0;
    res_stat  = STAT_OK;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        wu     = '0;
        wb     = '0;
        if (row_r == ROW_W'(ROWS - 1)) begin
          row_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end
      S_IDLE: begin
        if (cmd_pop) begin
          case (cmd_op)
            OP_ALLOC: begin
              row_nxt   = '0;
              state_nxt = S_READ;
            end
            OP_RELEASE, OP_MARK: begin
              row_nxt   = cmd_off[OFF_W-1:3];
              state_nxt = S_READ;
            end
            OP_REJECT: begin
              res_push = 1'b1;
              res_stat = STAT_OUT_OF_POOL;
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        case (op_r)
          OP_ALLOC: begin
            if (free != '0) begin
              mem_we    = 1'b1;
              wu        = rd_u_r | (ROW_BITS'(1) << sel);
              res_push  = 1'b1;
              res_frame = pool_base + FRAME_W'(row_idx) + FRAME_W'(sel);
              state_nxt = S_IDLE;
            end else if (alloc_last) begin
              res_push  = 1'b1;
              res_stat  = STAT_NONE_FREE;
              state_nxt = S_IDLE;
            end else begin
              row_nxt   = row_r + ROW_W'(1);
              state_nxt = S_READ;
            end
          end
          OP_RELEASE: begin
            mem_we    = 1'b1;
            wu        = rd_u_r & ~(ROW_BITS'(1) << off_r[2:0]);
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_MARK: begin
            mem_we = 1'b1;
            wb     = rd_b_r | mmask;
            if (mark_last) begin
              res_push  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              row_nxt   = row_r + ROW_W'(1);
              state_nxt = S_READ;
            end
          end
          default: begin
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  // latch the request being worked on
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op_r  <= cmd_op;
      off_r <= cmd_off;
      end_r <= cmd_end;
    end
  end

  // result queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (ocnt_r != 2'd2))
    else $error("result queue overflow");

  // evaluation always follows a row read
  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> ($past(state_r) == S_READ))
    else $error("eval without read");

  // a successful allocation reports its frame in the same cycle
  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && op_r == OP_ALLOC && mem_we) |-> (res_push && res_stat == STAT_OK))
    else $error("allocation without result");

  // no request starts during the clearing pass
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |=> (!cmd_pop || $past(state_nxt) == S_IDLE))
    else $error("request taken while clearing");

endmodule

>>> bench/tb_bitmap_frame_allocator_unit.sv
`timescale 1ns / 1ps
module tb_bitmap_frame_allocator_unit;
  import bfa_pkg::*;

  localparam int NFRAMES = MAX_FRAMES_DEF;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FRAME_W-1:0]  frame_number;
    logic [COUNT_W-1:0]  range_count;
  } request_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_out;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [ACTION_W-1:0]   in_action = '0;
  logic [FRAME_W-1:0]    in_frame_number = '0;
  logic [COUNT_W-1:0]    in_range_count = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [FRAME_W-1:0]    out_frame_out;
  logic [STATUS_W-1:0]   out_status;

  bitmap_frame_allocator_unit i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_push(in_push), .in_full(in_full),
    .in_action(in_action), .in_frame_number(in_frame_number),
    .in_range_count(in_range_count), .out_empty(out_empty), .out_pop(out_pop),
    .out_frame_out(out_frame_out), .out_status(out_status)
  );

  always #1 clk = ~clk;

  // shadow allocator state
  bit          used_bits [NFRAMES];
  bit          blocked_bits [NFRAMES];
  logic [19:0] shadow_base = '0;
  logic [13:0] shadow_size = '0;
  bit          shadow_info = 1'b1;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       mismatches = 0;
  bit       quiet = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;

  // accept flag as seen at the last rising edge
  logic in_full_q = 1'b1;

  function automatic answer_t allocator_answer(request_t r);
    answer_t a;
    longint  size;
    longint  fno;
    longint  base;
    a = '0;
    size = (shadow_size > NFRAMES) ? NFRAMES : shadow_size;
    fno = r.frame_number;
    base = shadow_base;
    case (action_t'(r.action))
      ACT_ALLOC: begin
        a.status = STAT_NONE_FREE;
        for (int i = 0; i < size; i++) begin
          if (i == 0 && shadow_info) continue;
          if (!used_bits[i] && !blocked_bits[i]) begin
            used_bits[i] = 1'b1;
            a.frame_out = 20'(base + i);
            a.status = STAT_OK;
            break;
          end
        end
      end
      ACT_RELEASE: begin
        if (fno < base || fno >= base + size) a.status = STAT_OUT_OF_POOL;
        else used_bits[fno - base] = 1'b0;
      end
      ACT_MARK: begin
        if (fno < base || fno + r.range_count > base + size) a.status = STAT_OUT_OF_POOL;
        else for (longint i = 0; i < r.range_count; i++) blocked_bits[fno - base + i] = 1'b1;
      end
      default: ;
    endcase
    return a;
  endfunction

  // driver: present queued requests and pop results, random idle bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full_q) begin
        void'(pending_requests.pop_front());
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_push <= 1'b0;
      end else if (pending_requests.size() > 0 && !(in_push && !in_full_q && !quiet &&
                   $urandom_range(0, 9) == 0)) begin
        in_push <= 1'b1;
        {in_action, in_frame_number, in_range_count} <= pending_requests[0];
      end else begin
        in_push <= 1'b0;
        if (!quiet && pending_requests.size() > 0) in_gap <= $urandom_range(0, 6);
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_pop <= 1'b0;
        out_gap <= $urandom_range(0, 6);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // monitor: predict on accept, compare on pop
  always @(posedge clk) begin
    answer_t want;
    in_full_q <= in_full;
    if (rst_n && in_push && !in_full) begin
      expected_answers.push_back(allocator_answer(
        request_t'{in_action, in_frame_number, in_range_count}));
    end
    if (rst_n && out_pop && !out_empty) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%0d", out_frame_out, out_status);
      end else begin
        want = expected_answers.pop_front();
        if (want.frame_out !== out_frame_out || want.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected frame %h status %0d, got frame %h status %0d",
                     want.frame_out, want.status, out_frame_out, out_status);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    repeat (2100) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [19:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POOL_BASE: shadow_base = value;
      CFG_POOL_SIZE: shadow_size = value[13:0];
      default:       shadow_info = value[0];
    endcase
  endtask

  function automatic request_t pool_request(int sz);
    request_t r;
    int       k;
    k = $urandom_range(0, 99);
    r.action = (k < 45) ? ACT_ALLOC : (k < 80) ? ACT_RELEASE : (k < 96) ? ACT_MARK : ACT_NONE;
    if ($urandom_range(0, 9) == 0) r.frame_number = 20'($urandom);
    else r.frame_number = 20'(shadow_base + $urandom_range(0, sz + 1) - 1);
    r.range_count = ($urandom_range(0, 19) == 0) ? 14'($urandom) : 14'($urandom_range(0, 6));
    return r;
  endfunction

  initial begin
    int sizes[6] = '{16, 40, 1, 0, 200, 8192};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: default config then a tiny pool
    pending_requests.push_back('{ACT_ALLOC, 20'd0, 14'd0});
    pending_requests.push_back('{ACT_RELEASE, 20'd0, 14'd0});
    pending_requests.push_back('{ACT_MARK, 20'd0, 14'd0});
    pending_requests.push_back('{ACT_NONE, 20'hFFFFF, 14'h3FFF});
    wait_drained();
    write_reg(CFG_POOL_BASE, 20'hFFFFC);
    write_reg(CFG_POOL_SIZE, 20'd9);
    write_reg(CFG_INFO, 20'd1);
    for (int i = 0; i < 9; i++) pending_requests.push_back('{ACT_ALLOC, 20'd0, 14'd0});
    pending_requests.push_back('{ACT_RELEASE, 20'hFFFFD, 14'd0});
    pending_requests.push_back('{ACT_RELEASE, 20'hFFFFD, 14'd0});
    pending_requests.push_back('{ACT_RELEASE, 20'hFFFFB, 14'd0});
    pending_requests.push_back('{ACT_RELEASE, 20'h00005, 14'd0});
    pending_requests.push_back('{ACT_MARK, 20'hFFFFC, 14'd9});
    pending_requests.push_back('{ACT_MARK, 20'hFFFFC, 14'd10});
    pending_requests.push_back('{ACT_MARK, 20'hFFFFE, 14'd0});
    pending_requests.push_back('{ACT_ALLOC, 20'd0, 14'd0});
    pending_requests.push_back('{ACT_NONE, 20'd0, 14'd0});
    wait_drained();

    // random phases over several pool settings
    for (int ph = 0; ph < 12; ph++) begin
      int sz;
      int n;
      sz = (ph < 6) ? sizes[ph] : $urandom_range(2, 64);
      if (ph == 7) sz = 16383;
      write_reg(CFG_POOL_BASE, (ph % 3 == 0) ? 20'hFFFFF - 20'($urandom_range(0, 30))
                                             : 20'($urandom));
      write_reg(CFG_POOL_SIZE, 20'(sz));
      write_reg(CFG_INFO, 20'(ph % 2));
      n = (sz >= 8192) ? 60 : 175;
      if (ph == 11) quiet = 1'b1;
      for (int i = 0; i < n; i++) pending_requests.push_back(pool_request(sz > 8192 ? 8192 : sz));
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
